### rtl/gmm_pkg.sv
// Shared types, constants and the exponent table for the Gaussian mixture background core.
// No dependencies; every other file imports this package.
package gmm_pkg;

  localparam int PIXELS_DEF = 65536;
  localparam int K_DEF      = 4;
  localparam int RANK_W     = 3;
  localparam int SUM_W      = 19;
  localparam int DIV_W      = 48;
  localparam int SQ_IN_W    = 34;
  localparam int SQ_W       = 17;
  localparam int PADDR_W    = 5;

  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [16:0] EXP_SCALE = 17'd94548;
  localparam logic [14:0] RHO_SCALE = 15'd26145;

  typedef enum logic [2:0] {
    REG_LEARNING_RATE      = 3'd0,
    REG_MATCH_THRESHOLD    = 3'd1,
    REG_BACKGROUND_PORTION = 3'd2,
    REG_INITIAL_SIGMA      = 3'd3,
    REG_MINIMUM_SIGMA      = 3'd4,
    REG_BACKGROUND_LEVEL   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] pixel_index;
    logic [15:0] pixel_value;
    logic        skip_update;
  } pixel_t;

  typedef struct packed {
    logic        foreground;
    logic        matched;
    logic [1:0]  match_rank;
    logic [15:0] background_value;
  } result_t;

  typedef struct packed {
    logic [15:0] learning_rate;
    logic [15:0] match_threshold;
    logic [15:0] background_portion;
    logic [15:0] initial_sigma;
    logic [15:0] minimum_sigma;
    logic [1:0]  background_level;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LATCH, OP_READ, OP_SCAN, OP_CLASS, OP_WSCALE, OP_SQ,
    OP_DIV_T, OP_EXP1, OP_EXP2, OP_EXP3, OP_RHO1, OP_DIV_RHO, OP_MU1, OP_MU2,
    OP_MU3, OP_VAR1, OP_VAR2, OP_VAR3, OP_SIG, OP_REPLACE, OP_SUM, OP_DIV_NORM,
    OP_NORM_WR, OP_SORT_MUL, OP_SORT_SWAP, OP_WRITE, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic [RANK_W-1:0]   idx;
    logic                phase;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic oob;
    logic skip;
    logic matched;
    logic div_done;
    logic sqrt_done;
    logic sum_zero;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_READ, S_SCAN, S_CLASS, S_WSCALE, S_SQ, S_DIV_T,
    S_WAIT_T, S_EXP1, S_EXP2, S_EXP3, S_RHO1, S_DIV_RHO, S_WAIT_RHO, S_MU1,
    S_MU2, S_MU3, S_VAR1, S_VAR2, S_VAR3, S_WAIT_SQ, S_SIG, S_REPLACE,
    S_SUM, S_NORM, S_WAIT_NORM, S_NORM_WR, S_SORT_MUL, S_SORT_SWAP, S_WRITE, S_OUT
  } state_t;

  function automatic logic [16:0] pow2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/gmm_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions of the core.
// Depends on gmm_pkg.
module gmm_div import gmm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic             done
);
  localparam int STEP_W = $clog2(DIV_W);

  logic [DIV_W-1:0]  quo;
  logic [DIV_W-1:0]  dsr;
  logic [DIV_W:0]    rem;
  logic [DIV_W:0]    rem_sh;
  logic              busy;
  logic [STEP_W-1:0] step;

  assign rem_sh   = {rem[DIV_W-1:0], quo[DIV_W-1]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      if (rem_sh >= {1'b0, dsr}) begin
        rem <= rem_sh - {1'b0, dsr};
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

### rtl/gmm_isqrt.sv
// Digit-by-digit integer square root, two operand bits per cycle.
// Depends on gmm_pkg.
module gmm_isqrt import gmm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SQ_IN_W-1:0] radicand,
  output logic [SQ_W-1:0]    root,
  output logic               done
);
  localparam int STEP_W = $clog2(SQ_W);

  logic [SQ_IN_W-1:0] src;
  logic [SQ_W+2:0]    rem;
  logic [SQ_W+2:0]    rem_sh;
  logic [SQ_W+2:0]    trial;
  logic               busy;
  logic [STEP_W-1:0]  step;

  assign rem_sh = {rem[SQ_W:0], src[SQ_IN_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(SQ_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      src  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      src <= {src[SQ_IN_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[SQ_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[SQ_W-2:0], 1'b0};
      end
    end
  end

endmodule

### rtl/gmm_dp.sv
// Datapath: mixture memories, per-pixel working registers, arithmetic steps, result register.
// Depends on gmm_pkg, gmm_div and gmm_isqrt.
module gmm_dp import gmm_pkg::*; #(
  parameter int PIXELS = PIXELS_DEF,
  parameter int K      = K_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  input  cfg_t     cfg,
  input  pixel_t   pixel,
  output result_t  result,
  output logic     result_valid,
  input  logic     result_ready
);
  localparam int KW     = $clog2(K);
  localparam int PIX_AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int ST_AW  = PIX_AW + KW;
  localparam logic [15:0] W_INIT = 16'(65536 / K);

  logic [47:0] store_mem [2**ST_AW];
  logic        init_mem  [2**PIX_AW];
  logic [47:0] store_q;
  logic        init_q;
  logic        store_we;
  logic [ST_AW-1:0] store_waddr;
  logic [ST_AW-1:0] store_raddr;
  logic        init_we;
  logic        init_wdata;
  logic [PIX_AW-1:0] init_addr;
  logic [PIX_AW-1:0] clr_addr;

  logic [15:0] init_mu [K];
  for (genvar g = 0; g < K; g++) begin : g_init_mu
    localparam logic [15:0] MU0 = 16'(((g + 1) * 65536) / (K + 1));
    assign init_mu[g] = MU0;
  end

  logic [15:0] w  [K];
  logic [15:0] mu [K];
  logic [15:0] sg [K];
  logic [31:0] prod_hi [K-1];
  logic [31:0] prod_lo [K-1];

  logic [15:0] pix_idx, pix_val;
  logic        pix_skip;
  logic [PIX_AW-1:0] pix_addr;
  logic        oob;

  logic          rd_pend;
  logic [KW-1:0] rd_idx;
  logic [KW-1:0] sel, lvl_sel;
  logic [15:0]   w_sel, mu_sel, sg_sel;

  logic          match_found, lim_found;
  logic [KW-1:0] match_idx, lim_idx;
  logic [SUM_W-1:0] sum_run, nsum;
  logic          fg, mt;
  logic [1:0]    rank;

  logic [15:0] a, init_sig1, min_sig1;
  logic [16:0] inv_a;

  logic [15:0] s;
  logic [31:0] s2, d2, nd2;
  logic [21:0] u;
  logic        t_big, e_zero;
  logic [4:0]  ex_n;
  logic [16:0] ex_base;
  logic [23:0] ex_prod;
  logic [16:0] e;
  logic [30:0] ka;
  logic [47:0] num;
  logic [16:0] rho;
  logic [32:0] p1, p2;
  logic [15:0] nd;
  logic [48:0] q1, q2;

  logic             div_start, sq_start;
  logic [DIV_W-1:0] div_a, div_b, quo;
  logic             div_done, sq_done;
  logic [SQ_W-1:0]  sq_root;

  logic [15:0] scan_d;
  logic [SUM_W-1:0] scan_sum;
  logic [32:0] ws_prod;
  logic [17:0] ws_new;
  logic [33:0] mu_sum;
  logic [15:0] mu_new;
  logic [49:0] var_sum;
  logic [3:0]  ex_idx;
  logic [16:0] ex_diff;
  logic [16:0] ex_lin;
  logic [15:0] sig_new;

  assign a         = cfg.learning_rate;
  assign inv_a     = ONE_Q16 - {1'b0, a};
  assign init_sig1 = (cfg.initial_sigma == 16'd0) ? 16'd1 : cfg.initial_sigma;
  assign min_sig1  = (cfg.minimum_sigma == 16'd0) ? 16'd1 : cfg.minimum_sigma;
  assign pix_addr  = PIX_AW'(pix_idx);
  assign oob       = 32'(pix_idx) >= 32'(PIXELS);
  assign lvl_sel   = (32'(cfg.background_level) >= 32'(K)) ? KW'(K - 1)
                                                             : KW'(cfg.background_level);

  always_comb begin
    if (cmd.op inside {OP_SQ, OP_MU2, OP_MU3, OP_SIG}) begin
      sel = match_idx;
    end else if (cmd.op == OP_OUT) begin
      sel = lvl_sel;
    end else begin
      sel = cmd.idx[KW-1:0];
    end
  end

  assign w_sel  = w[sel];
  assign mu_sel = mu[sel];
  assign sg_sel = sg[sel];

  always_comb begin
    scan_d   = (pix_val > mu_sel) ? pix_val - mu_sel : mu_sel - pix_val;
    scan_sum = sum_run + SUM_W'(w_sel);
    ws_prod  = 33'(inv_a) * 33'(w_sel);
    ws_new   = 18'(ws_prod[32:16]) + ((sel == match_idx) ? 18'(a) : 18'd0);
    mu_sum   = 34'(p1) + 34'(p2);
    mu_new   = mu_sum[31:16];
    var_sum  = 50'(q1) + 50'(q2);
    ex_idx   = u[15:12];
    ex_diff  = pow2_tab({1'b0, ex_idx}) - pow2_tab(5'({1'b0, ex_idx}) + 5'd1);
    ex_lin   = ex_base - 17'(ex_prod[23:12]);
    if (sq_root > SQ_W'(16'hFFFF)) begin
      sig_new = 16'hFFFF;
    end else if (16'(sq_root) < min_sig1) begin
      sig_new = min_sig1;
    end else begin
      sig_new = 16'(sq_root);
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    case (cmd.op)
      OP_DIV_T: begin
        div_start = 1'b1;
        div_a     = {d2, 16'h0000};
        div_b     = DIV_W'({s2, 1'b0});
      end
      OP_DIV_RHO: begin
        div_start = 1'b1;
        div_a     = num;
        div_b     = DIV_W'({s, 16'h0000});
      end
      OP_DIV_NORM: begin
        div_start = 1'b1;
        div_a     = DIV_W'({w_sel, 16'h0000});
        div_b     = DIV_W'(nsum);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign sq_start = (cmd.op == OP_VAR3);

  gmm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (quo),
    .done     (div_done)
  );

  gmm_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (var_sum[SQ_IN_W+15:16]),
    .root     (sq_root),
    .done     (sq_done)
  );

  assign store_we    = (cmd.op == OP_WRITE);
  assign store_waddr = {pix_addr, sel};
  assign store_raddr = {pix_addr, cmd.idx[KW-1:0]};
  assign init_we     = (cmd.op == OP_CLEAR) || (cmd.op == OP_WRITE);
  assign init_wdata  = (cmd.op == OP_WRITE);
  assign init_addr   = (cmd.op == OP_CLEAR) ? clr_addr : pix_addr;

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= {w_sel, mu_sel, sg_sel};
    end
    store_q <= store_mem[store_raddr];
  end

  always_ff @(posedge clk) begin
    if (init_we) begin
      init_mem[init_addr] <= init_wdata;
    end
    init_q <= init_mem[init_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      rd_pend      <= 1'b0;
      rd_idx       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      rd_pend <= (cmd.op == OP_READ);
      rd_idx  <= cmd.idx[KW-1:0];
      if (cmd.op == OP_OUT) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      w[rd_idx]  <= init_q ? store_q[47:32] : W_INIT;
      mu[rd_idx] <= init_q ? store_q[31:16] : init_mu[rd_idx];
      sg[rd_idx] <= init_q ? store_q[15:0]  : init_sig1;
    end
    case (cmd.op)
      OP_LATCH: begin
        pix_idx     <= pixel.pixel_index;
        pix_val     <= pixel.pixel_value;
        pix_skip    <= pixel.skip_update;
        match_found <= 1'b0;
        lim_found   <= 1'b0;
        match_idx   <= '0;
        lim_idx     <= '0;
        sum_run     <= '0;
      end
      OP_SCAN: begin
        sum_run <= scan_sum;
        if (!match_found &&
            32'({scan_d, 12'h000}) < 32'(cfg.match_threshold) * 32'(sg_sel)) begin
          match_found <= 1'b1;
          match_idx   <= sel;
        end
        if (!lim_found && scan_sum > SUM_W'(cfg.background_portion)) begin
          lim_found <= 1'b1;
          lim_idx   <= sel;
        end
      end
      OP_CLASS: begin
        fg   <= !match_found ||
                (match_idx > (lim_found ? lim_idx : KW'(K - 1)));
        mt   <= match_found;
        rank <= match_found ? 2'(match_idx) : 2'd0;
        nsum <= '0;
      end
      OP_WSCALE: begin
        w[sel] <= (ws_new > 18'h0FFFF) ? 16'hFFFF : ws_new[15:0];
      end
      OP_SQ: begin
        s  <= (sg_sel == 16'd0) ? 16'd1 : sg_sel;
        s2 <= 32'((sg_sel == 16'd0) ? 16'd1 : sg_sel) *
              32'((sg_sel == 16'd0) ? 16'd1 : sg_sel);
        d2 <= 32'(scan_d) * 32'(scan_d);
      end
      OP_EXP1: begin
        t_big <= (quo[DIV_W-1:21] != '0);
        u     <= 22'((38'(quo[20:0]) * 38'(EXP_SCALE)) >> 16);
      end
      OP_EXP2: begin
        e_zero  <= t_big || (u[21:16] >= 6'd17);
        ex_n    <= u[20:16];
        ex_base <= pow2_tab({1'b0, ex_idx});
        ex_prod <= 24'(ex_diff[11:0]) * 24'(u[11:0]);
      end
      OP_EXP3: begin
        e  <= e_zero ? 17'd0 : (ex_lin >> ex_n);
        ka <= 31'(a) * 31'(RHO_SCALE);
      end
      OP_RHO1: begin
        num <= 48'(ka) * 48'(e);
      end
      OP_MU1: begin
        rho <= (quo > DIV_W'(ONE_Q16)) ? ONE_Q16 : quo[16:0];
      end
      OP_MU2: begin
        p1 <= 33'(ONE_Q16 - rho) * 33'(mu_sel);
        p2 <= 33'(rho) * 33'(pix_val);
      end
      OP_MU3: begin
        mu[sel] <= mu_new;
        nd      <= (pix_val > mu_new) ? pix_val - mu_new : mu_new - pix_val;
      end
      OP_VAR1: begin
        q1  <= 49'(ONE_Q16 - rho) * 49'(s2);
        nd2 <= 32'(nd) * 32'(nd);
      end
      OP_VAR2: begin
        q2 <= 49'(rho) * 49'(nd2);
      end
      OP_SIG: begin
        sg[sel] <= sig_new;
      end
      OP_REPLACE: begin
        w[K-1]  <= a;
        mu[K-1] <= pix_val;
        sg[K-1] <= init_sig1;
      end
      OP_SUM: begin
        nsum <= nsum + SUM_W'(w_sel);
      end
      OP_NORM_WR: begin
        w[sel] <= (quo > DIV_W'(16'hFFFF)) ? 16'hFFFF : quo[15:0];
      end
      OP_SORT_MUL: begin
        for (int p = 0; p < K - 1; p++) begin
          prod_hi[p] <= 32'(w[p+1]) * 32'(sg[p]);
          prod_lo[p] <= 32'(w[p]) * 32'(sg[p+1]);
        end
      end
      OP_SORT_SWAP: begin
        for (int p = 0; p < K - 1; p++) begin
          if ((p % 2 == 32'(cmd.phase)) && (prod_hi[p] > prod_lo[p])) begin
            w[p]    <= w[p+1];
            w[p+1]  <= w[p];
            mu[p]   <= mu[p+1];
            mu[p+1] <= mu[p];
            sg[p]   <= sg[p+1];
            sg[p+1] <= sg[p];
          end
        end
      end
      OP_OUT: begin
        if (oob) begin
          result <= '0;
        end else begin
          result.foreground       <= fg;
          result.matched          <= mt;
          result.match_rank       <= rank;
          result.background_value <= mu_sel;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.clr_last  = (32'(clr_addr) == 32'(PIXELS - 1));
    stat.oob       = oob;
    stat.skip      = pix_skip;
    stat.matched   = match_found;
    stat.div_done  = div_done;
    stat.sqrt_done = sq_done;
    stat.sum_zero  = (nsum == '0);
    stat.out_free  = !result_valid || result_ready;
  end

endmodule

### rtl/gmm_ctrl.sv
// Sequencer: steps one pixel through read, classify, update, normalize, sort and write back.
// Depends on gmm_pkg; drives gmm_dp through dp_cmd_t and reads dp_stat_t.
module gmm_ctrl import gmm_pkg::*; #(
  parameter int K = K_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     pixel_valid,
  output logic     pixel_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);
  localparam int CW = $clog2(K + 1);

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          last;

  assign last = (cnt == CW'(K - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    pixel_ready = 1'b0;
    cmd.op      = OP_NONE;
    cmd.idx     = RANK_W'(cnt);
    cmd.phase   = cnt[0];
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        pixel_ready = 1'b1;
        if (pixel_valid) begin
          cmd.op     = OP_LATCH;
          cnt_next   = '0;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (stat.oob) begin
          state_next = S_OUT;
        end else if (cnt == CW'(K)) begin
          cnt_next   = '0;
          state_next = S_SCAN;
        end else begin
          cmd.op   = OP_READ;
          cnt_next = cnt + 1'b1;
        end
      end
      S_SCAN: begin
        cmd.op   = OP_SCAN;
        cnt_next = last ? '0 : cnt + 1'b1;
        if (last) state_next = S_CLASS;
      end
      S_CLASS: begin
        cmd.op   = OP_CLASS;
        cnt_next = '0;
        if (stat.skip) begin
          state_next = S_WRITE;
        end else if (stat.matched) begin
          state_next = S_WSCALE;
        end else begin
          state_next = S_REPLACE;
        end
      end
      S_WSCALE: begin
        cmd.op   = OP_WSCALE;
        cnt_next = last ? '0 : cnt + 1'b1;
        if (last) state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op     = OP_SQ;
        state_next = S_DIV_T;
      end
      S_DIV_T: begin
        cmd.op     = OP_DIV_T;
        state_next = S_WAIT_T;
      end
      S_WAIT_T: begin
        if (stat.div_done) state_next = S_EXP1;
      end
      S_EXP1: begin
        cmd.op     = OP_EXP1;
        state_next = S_EXP2;
      end
      S_EXP2: begin
        cmd.op     = OP_EXP2;
        state_next = S_EXP3;
      end
      S_EXP3: begin
        cmd.op     = OP_EXP3;
        state_next = S_RHO1;
      end
      S_RHO1: begin
        cmd.op     = OP_RHO1;
        state_next = S_DIV_RHO;
      end
      S_DIV_RHO: begin
        cmd.op     = OP_DIV_RHO;
        state_next = S_WAIT_RHO;
      end
      S_WAIT_RHO: begin
        if (stat.div_done) state_next = S_MU1;
      end
      S_MU1: begin
        cmd.op     = OP_MU1;
        state_next = S_MU2;
      end
      S_MU2: begin
        cmd.op     = OP_MU2;
        state_next = S_MU3;
      end
      S_MU3: begin
        cmd.op     = OP_MU3;
        state_next = S_VAR1;
      end
      S_VAR1: begin
        cmd.op     = OP_VAR1;
        state_next = S_VAR2;
      end
      S_VAR2: begin
        cmd.op     = OP_VAR2;
        state_next = S_VAR3;
      end
      S_VAR3: begin
        cmd.op     = OP_VAR3;
        state_next = S_WAIT_SQ;
      end
      S_WAIT_SQ: begin
        if (stat.sqrt_done) state_next = S_SIG;
      end
      S_SIG: begin
        cmd.op     = OP_SIG;
        cnt_next   = '0;
        state_next = S_SUM;
      end
      S_REPLACE: begin
        cmd.op     = OP_REPLACE;
        cnt_next   = '0;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op   = OP_SUM;
        cnt_next = last ? '0 : cnt + 1'b1;
        if (last) state_next = S_NORM;
      end
      S_NORM: begin
        if (stat.sum_zero) begin
          cnt_next   = '0;
          state_next = S_SORT_MUL;
        end else begin
          cmd.op     = OP_DIV_NORM;
          state_next = S_WAIT_NORM;
        end
      end
      S_WAIT_NORM: begin
        if (stat.div_done) state_next = S_NORM_WR;
      end
      S_NORM_WR: begin
        cmd.op   = OP_NORM_WR;
        cnt_next = last ? '0 : cnt + 1'b1;
        state_next = last ? S_SORT_MUL : S_NORM;
      end
      S_SORT_MUL: begin
        cmd.op     = OP_SORT_MUL;
        state_next = S_SORT_SWAP;
      end
      S_SORT_SWAP: begin
        cmd.op     = OP_SORT_SWAP;
        cnt_next   = last ? '0 : cnt + 1'b1;
        state_next = last ? S_WRITE : S_SORT_MUL;
      end
      S_WRITE: begin
        cmd.op   = OP_WRITE;
        cnt_next = last ? '0 : cnt + 1'b1;
        if (last) state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/gmm_background_subtractor_core.sv
// Top level of the Gaussian mixture background core: APB registers, sequencer, datapath.
// Depends on gmm_pkg, gmm_ctrl and gmm_dp.
//
//   port group    kind         transfer when
//   pixel         valid/ready  pixel_valid & pixel_ready
//   result        valid/ready  result_valid & result_ready
//   apb           psel/penable psel & penable & pready (write when pwrite)
//
// Time from one pixel accept to the next depends on the path: a skip, a match update or a
// replace (shorter when the new weights sum to zero); the shared divider (48 steps,
// up to K+2 divisions) and the 17-step square root set it.
// After reset the pixel flags are cleared, one per cycle, for all PIXELS entries, before the first
// pixel is taken. A stalled result holds the block in its last step until taken.
module gmm_background_subtractor_core import gmm_pkg::*; #(
  parameter int PIXELS = PIXELS_DEF,
  parameter int K      = K_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_ready,
  input  pixel_t             pixel,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  reg_idx_t ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.learning_rate      <= 16'd66;
      cfg.match_threshold    <= 16'd10240;
      cfg.background_portion <= 16'd32768;
      cfg.initial_sigma      <= 16'd7864;
      cfg.minimum_sigma      <= 16'd4915;
      cfg.background_level   <= 2'd0;
    end else if (psel && penable && pwrite && pready) begin
      case (ridx)
        REG_LEARNING_RATE:      cfg.learning_rate      <= pwdata[15:0];
        REG_MATCH_THRESHOLD:    cfg.match_threshold    <= pwdata[15:0];
        REG_BACKGROUND_PORTION: cfg.background_portion <= pwdata[15:0];
        REG_INITIAL_SIGMA:      cfg.initial_sigma      <= pwdata[15:0];
        REG_MINIMUM_SIGMA:      cfg.minimum_sigma      <= pwdata[15:0];
        REG_BACKGROUND_LEVEL:   cfg.background_level   <= pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_LEARNING_RATE:      prdata = 32'(cfg.learning_rate);
      REG_MATCH_THRESHOLD:    prdata = 32'(cfg.match_threshold);
      REG_BACKGROUND_PORTION: prdata = 32'(cfg.background_portion);
      REG_INITIAL_SIGMA:      prdata = 32'(cfg.initial_sigma);
      REG_MINIMUM_SIGMA:      prdata = 32'(cfg.minimum_sigma);
      REG_BACKGROUND_LEVEL:   prdata = 32'(cfg.background_level);
      default:                prdata = 32'd0;
    endcase
  end

  gmm_ctrl #(.K(K)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  gmm_dp #(.PIXELS(PIXELS), .K(K)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg          (cfg),
    .pixel        (pixel),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

### rtl/gmm_checker.sv
// Port-level checks for the Gaussian mixture background core, bound to the top level.
// Depends on gmm_pkg.
module gmm_checker import gmm_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    pixel_valid,
  input logic    pixel_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready |=> !pixel_ready)
    else $error("pixel taken while previous one in work");

  a_unmatched_fg: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.matched |-> result.foreground && result.match_rank == 2'd0)
    else $error("unmatched pixel not foreground at rank zero");

endmodule

bind gmm_background_subtractor_core gmm_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel_valid),
  .pixel_ready  (pixel_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

### tb/tb.sv
// Testbench for gmm_background_subtractor_core: random and directed pixel transfers with a
// built-in mixture predictor, APB register writes between phases, randomized back-pressure.
// Depends on gmm_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;
  import gmm_pkg::*;

  localparam int NPIX = PIXELS_DEF;
  localparam int NG   = K_DEF;

  logic clk = 0;
  logic rst = 1;
  logic pixel_valid = 0;
  logic pixel_ready;
  pixel_t pixel = '0;
  logic result_valid;
  logic result_ready = 0;
  result_t result;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gmm_background_subtractor_core dut (.*);

  always #4 clk = ~clk;

  // mixture state
  logic [15:0] mix_w [int][NG];
  logic [15:0] mix_mu [int][NG];
  logic [15:0] mix_sg [int][NG];
  bit          touched [int];
  cfg_t        cfg;

  pixel_t  pending_px [$];
  result_t expected_res [$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  logic hold_off = 0;

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] exp_neg(input logic [63:0] t);
    logic [63:0] u, n, f, ix, r, v, p0, p1;
    if (t >= (64'd32 << 16)) return 0;
    u = (t * 94548) >> 16;
    n = u >> 16;
    if (n >= 17) return 0;
    f = u & 64'hFFFF;
    ix = f >> 12;
    r = f & 64'hFFF;
    p0 = pow2_tab(ix[4:0]);
    p1 = pow2_tab(ix[4:0] + 5'd1);
    v = p0 - (((p0 - p1) * r) >> 12);
    return v >> n;
  endfunction

  function automatic result_t classify_and_adapt(input pixel_t px);
    result_t o;
    logic [63:0] w [NG], mu [NG], sg [NG];
    logic [63:0] a, sum, d, s, s2, t, e, rho, nd, vr, ns, nw, cw, cm, cs, v, isg, msg;
    int i, j, m, lim, lvl, p;
    o = '0;
    p = px.pixel_index;
    v = px.pixel_value;
    a = cfg.learning_rate;
    isg = cfg.initial_sigma == 0 ? 1 : cfg.initial_sigma;
    msg = cfg.minimum_sigma == 0 ? 1 : cfg.minimum_sigma;
    m = -1;
    lim = -1;
    if (p >= NPIX) return o;
    if (!touched.exists(p)) begin
      for (i = 0; i < NG; i++) begin
        mix_w[p][i] = 16'(65536 / NG);
        mix_mu[p][i] = 16'(((i + 1) * 65536) / (NG + 1));
        mix_sg[p][i] = 16'(isg);
      end
      touched[p] = 1;
    end
    for (i = 0; i < NG; i++) begin
      w[i] = mix_w[p][i];
      mu[i] = mix_mu[p][i];
      sg[i] = mix_sg[p][i];
    end
    sum = 0;
    for (i = 0; i < NG; i++) begin
      d = v > mu[i] ? v - mu[i] : mu[i] - v;
      if (m < 0 && (d << 12) < cfg.match_threshold * sg[i]) m = i;
      sum += w[i];
      if (lim < 0 && sum > cfg.background_portion) lim = i;
    end
    if (lim < 0) lim = NG - 1;
    o.foreground = (m < 0 || m > lim);
    o.matched = m >= 0;
    o.match_rank = m >= 0 ? m[1:0] : 2'd0;
    if (!px.skip_update) begin
      if (m >= 0) begin
        for (i = 0; i < NG; i++) begin
          nw = ((65536 - a) * w[i]) >> 16;
          if (i == m) begin
            s = sg[i] == 0 ? 1 : sg[i];
            d = v > mu[i] ? v - mu[i] : mu[i] - v;
            s2 = s * s;
            t = ((d * d) << 16) / (2 * s2);
            e = exp_neg(t);
            rho = (a * 26145 * e) / (s << 16);
            if (rho > 65536) rho = 65536;
            nw += a;
            mu[i] = ((65536 - rho) * mu[i] + rho * v) >> 16;
            nd = v > mu[i] ? v - mu[i] : mu[i] - v;
            vr = ((65536 - rho) * s2 + rho * nd * nd) >> 16;
            ns = isqrt(vr);
            if (ns < msg) ns = msg;
            if (ns > 65535) ns = 65535;
            sg[i] = ns;
          end
          if (nw > 65535) nw = 65535;
          w[i] = nw;
        end
      end else begin
        w[NG-1] = a;
        mu[NG-1] = v;
        sg[NG-1] = isg;
      end
      sum = 0;
      for (i = 0; i < NG; i++) sum += w[i];
      if (sum != 0)
        for (i = 0; i < NG; i++) begin
          nw = (w[i] << 16) / sum;
          w[i] = nw > 65535 ? 65535 : nw;
        end
      for (i = 1; i < NG; i++) begin
        cw = w[i];
        cm = mu[i];
        cs = sg[i];
        j = i - 1;
        while (j >= 0 && cw * sg[j] > w[j] * cs) begin
          w[j+1] = w[j];
          mu[j+1] = mu[j];
          sg[j+1] = sg[j];
          j--;
        end
        w[j+1] = cw;
        mu[j+1] = cm;
        sg[j+1] = cs;
      end
      for (i = 0; i < NG; i++) begin
        mix_w[p][i] = 16'(w[i]);
        mix_mu[p][i] = 16'(mu[i]);
        mix_sg[p][i] = 16'(sg[i]);
      end
    end
    lvl = cfg.background_level;
    if (lvl >= NG) lvl = NG - 1;
    o.background_value = mu[lvl][15:0];
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 0;
    end else if (!pixel_valid || pixel_ready) begin
      if (pending_px.size() > 0 && $urandom_range(99) >= send_idle) begin
        pixel <= pending_px[0];
        expected_res.insert(expected_res.size(), classify_and_adapt(pending_px.pop_front()));
        pixel_valid <= 1;
      end else begin
        pixel_valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_res.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          result_t x;
          x = expected_res.pop_front();
          if (result.foreground !== x.foreground) begin
            $error("foreground exp %0d got %0d", x.foreground, result.foreground);
            errors++;
          end
          if (result.matched !== x.matched) begin
            $error("matched exp %0d got %0d", x.matched, result.matched);
            errors++;
          end
          if (result.match_rank !== x.match_rank) begin
            $error("match_rank exp %0d got %0d", x.match_rank, result.match_rank);
            errors++;
          end
          if (result.background_value !== x.background_value) begin
            $error("background_value exp %0d got %0d", x.background_value,
                   result.background_value);
            errors++;
          end
        end
      end
      if (hold_off) begin
        result_ready <= 0;
      end else begin
        result_ready <= $urandom_range(99) >= recv_idle;
      end
    end
  end

  task automatic add_pixel(input pixel_t px);
    pending_px.insert(pending_px.size(), px);
  endtask

  task automatic apb_write(input reg_idx_t r, input logic [15:0] val);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= PADDR_W'(4 * r);
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (r)
      REG_LEARNING_RATE:      cfg.learning_rate = val;
      REG_MATCH_THRESHOLD:    cfg.match_threshold = val;
      REG_BACKGROUND_PORTION: cfg.background_portion = val;
      REG_INITIAL_SIGMA:      cfg.initial_sigma = val;
      REG_MINIMUM_SIGMA:      cfg.minimum_sigma = val;
      REG_BACKGROUND_LEVEL:   cfg.background_level = val[1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_px.size() > 0 || expected_res.size() > 0 || pixel_valid) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel(input int hot);
    pixel_t px;
    px.pixel_index = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(hot));
    case ($urandom_range(3))
      0: px.pixel_value = 16'($urandom);
      1: px.pixel_value = 16'(13107 * $urandom_range(1, 4) + $urandom_range(2000) - 1000);
      default: px.pixel_value = 16'(30000 + $urandom_range(800));
    endcase
    px.skip_update = ($urandom_range(7) == 0);
    return px;
  endfunction

  task automatic run_phase(input int n, input int hot, input int si, input int ri);
    send_idle = si;
    recv_idle = ri;
    repeat (n) add_pixel(rand_pixel(hot));
    drain();
  endtask

  initial begin
    cfg = '{learning_rate: 66, match_threshold: 10240, background_portion: 32768,
            initial_sigma: 7864, minimum_sigma: 4915, background_level: 0};
    repeat (12) @(posedge clk);
    rst <= 0;
    // directed
    send_idle = 0;
    recv_idle = 0;
    add_pixel('{16'd0, 16'd0, 1'b0});
    add_pixel('{16'd0, 16'd65535, 1'b0});
    add_pixel('{16'd0, 16'd13107, 1'b1});
    add_pixel('{16'd0, 16'd13107, 1'b0});
    add_pixel('{16'd65535, 16'd52428, 1'b0});
    add_pixel('{16'd65535, 16'd52428, 1'b1});
    add_pixel('{16'd1, 16'd39321, 1'b1});
    add_pixel('{16'd1, 16'd39321, 1'b0});
    add_pixel('{16'd2, 16'd26214, 1'b0});
    add_pixel('{16'd2, 16'd26300, 1'b0});
    add_pixel('{16'd43690, 16'd21845, 1'b0});
    add_pixel('{16'd21845, 16'd43690, 1'b1});
    drain();
    apb_write(REG_LEARNING_RATE, 16'd65535);
    apb_write(REG_MATCH_THRESHOLD, 16'd65535);
    apb_write(REG_BACKGROUND_PORTION, 16'd0);
    apb_write(REG_INITIAL_SIGMA, 16'd0);
    apb_write(REG_MINIMUM_SIGMA, 16'd0);
    apb_write(REG_BACKGROUND_LEVEL, 16'd3);
    add_pixel('{16'd3, 16'd100, 1'b0});
    add_pixel('{16'd3, 16'd100, 1'b0});
    add_pixel('{16'd0, 16'd65535, 1'b0});
    add_pixel('{16'd4, 16'd0, 1'b0});
    drain();
    apb_write(REG_MATCH_THRESHOLD, 16'd0);
    apb_write(REG_BACKGROUND_PORTION, 16'd65535);
    apb_write(REG_INITIAL_SIGMA, 16'd65535);
    apb_write(REG_MINIMUM_SIGMA, 16'd65535);
    apb_write(REG_BACKGROUND_LEVEL, 16'd1);
    add_pixel('{16'd5, 16'd32768, 1'b0});
    add_pixel('{16'd1, 16'd12345, 1'b0});
    drain();
    // defaults, long receiver hold-off to stall the core at its result output
    apb_write(REG_LEARNING_RATE, 16'd66);
    apb_write(REG_MATCH_THRESHOLD, 16'd10240);
    apb_write(REG_BACKGROUND_PORTION, 16'd32768);
    apb_write(REG_INITIAL_SIGMA, 16'd7864);
    apb_write(REG_MINIMUM_SIGMA, 16'd4915);
    apb_write(REG_BACKGROUND_LEVEL, 16'd0);
    fork
      begin
        hold_off <= 1;
        repeat (3000) @(posedge clk);
        hold_off <= 0;
      end
    join_none
    run_phase(150, 15, 33, 63);
    apb_write(REG_LEARNING_RATE, 16'd3000);
    apb_write(REG_BACKGROUND_PORTION, 16'd50000);
    apb_write(REG_MINIMUM_SIGMA, 16'd1000);
    apb_write(REG_BACKGROUND_LEVEL, 16'd2);
    run_phase(150, 31, 63, 33);
    apb_write(REG_LEARNING_RATE, 16'd20000);
    apb_write(REG_MATCH_THRESHOLD, 16'd16384);
    apb_write(REG_INITIAL_SIGMA, 16'd3000);
    apb_write(REG_BACKGROUND_LEVEL, 16'd1);
    run_phase(150, 7, 0, 0);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
